### sv/rosc_pkg.sv
`timescale 1ns / 1ps

package rosc_pkg;

  // register byte offsets
  localparam logic [7:0] OFS_CTRL      = 8'h00;
  localparam logic [7:0] OFS_FREQA     = 8'h04;
  localparam logic [7:0] OFS_FREQB     = 8'h08;
  localparam logic [7:0] OFS_DORMANT   = 8'h0C;
  localparam logic [7:0] OFS_DIV       = 8'h10;
  localparam logic [7:0] OFS_PHASE     = 8'h14;
  localparam logic [7:0] OFS_STATUS    = 8'h18;
  localparam logic [7:0] OFS_RANDOMBIT = 8'h1C;
  localparam logic [7:0] OFS_COUNT     = 8'h20;

  // access kinds
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  localparam logic [11:0] ENABLE_OFF_CODE = 12'hD1E;
  localparam logic [15:0] FREQ_PASSWORD   = 16'h9696;

  // status bit positions
  localparam int ST_ENABLED     = 12;
  localparam int ST_DIV_RUNNING = 16;
  localparam int ST_BADWRITE    = 24;
  localparam int ST_STABLE      = 31;

  typedef struct packed {
    logic        mode;
    logic [7:0]  reg_offset;
    logic [31:0] write_data;
  } rosc_access_t;

endpackage

### sv/rosc_regs.sv
`timescale 1ns / 1ps

module rosc_regs (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  rosc_pkg::rosc_access_t acc,
  output logic [31:0]           rdata
);
  import rosc_pkg::*;

  logic [31:0] control_word;
  logic [15:0] freq_a_word;
  logic [15:0] freq_b_word;
  logic [31:0] dormant_word;
  logic [11:0] divider_word;
  logic [11:0] phase_word;
  logic        bad_write_flag;
  logic        random_bit;

  logic osc_on;
  logic pw_ok;
  logic is_write;
  logic is_read;

  assign osc_on   = control_word[23:12] != ENABLE_OFF_CODE;
  assign pw_ok    = acc.write_data[31:16] == FREQ_PASSWORD;
  assign is_write = fire && (acc.mode == MODE_WRITE);
  assign is_read  = fire && (acc.mode == MODE_READ);

  // read mux, zero on writes
  always_comb begin
    rdata = 32'd0;
    if (acc.mode == MODE_READ) begin
      unique case (acc.reg_offset)
        OFS_CTRL:      rdata = control_word;
        OFS_FREQA:     rdata = {16'd0, freq_a_word};
        OFS_FREQB:     rdata = {16'd0, freq_b_word};
        OFS_DORMANT:   rdata = dormant_word;
        OFS_DIV:       rdata = {20'd0, divider_word};
        OFS_PHASE:     rdata = {20'd0, phase_word};
        OFS_STATUS: begin
          rdata[ST_ENABLED]     = osc_on;
          rdata[ST_DIV_RUNNING] = osc_on;
          rdata[ST_STABLE]      = osc_on;
          rdata[ST_BADWRITE]    = bad_write_flag;
        end
        OFS_RANDOMBIT: rdata = {31'd0, random_bit};
        default:       rdata = 32'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_word   <= 32'd0;
      freq_a_word    <= 16'd0;
      freq_b_word    <= 16'd0;
      dormant_word   <= 32'd0;
      divider_word   <= 12'd0;
      phase_word     <= 12'd0;
      bad_write_flag <= 1'b0;
      random_bit     <= 1'b0;
    end else begin
      if (is_read && acc.reg_offset == OFS_RANDOMBIT) begin
        random_bit <= ~random_bit;
      end
      if (is_write) begin
        unique case (acc.reg_offset)
          OFS_CTRL:    control_word <= acc.write_data;
          OFS_FREQA: begin
            if (pw_ok) freq_a_word <= acc.write_data[15:0];
            else       bad_write_flag <= 1'b1;
          end
          OFS_FREQB: begin
            if (pw_ok) freq_b_word <= acc.write_data[15:0];
            else       bad_write_flag <= 1'b1;
          end
          OFS_DORMANT: dormant_word <= acc.write_data;
          OFS_DIV:     divider_word <= acc.write_data[11:0];
          OFS_PHASE:   phase_word   <= acc.write_data[11:0];
          OFS_STATUS: begin
            if (acc.write_data[ST_BADWRITE]) bad_write_flag <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTH
  a_bad_pw_sets_flag: assert property (@(posedge clk) disable iff (rst)
    is_write && (acc.reg_offset == OFS_FREQA || acc.reg_offset == OFS_FREQB) && !pw_ok
    |=> bad_write_flag)
    else $error("bad password write did not raise flag");

  a_rbit_toggles: assert property (@(posedge clk) disable iff (rst)
    is_read && acc.reg_offset == OFS_RANDOMBIT |=> random_bit != $past(random_bit))
    else $error("random bit did not toggle on read");

  a_freq_guarded: assert property (@(posedge clk) disable iff (rst)
    is_write && acc.reg_offset == OFS_FREQA && !pw_ok |=> $stable(freq_a_word))
    else $error("freq a changed without password");
`endif

endmodule

### sv/ring_oscillator_registers.sv
`timescale 1ns / 1ps

// channel  | handshake          | payload
// ---------+--------------------+--------------------------------
// access   | in_valid/in_ready  | mode, reg_offset, write_data
// result   | out_valid/out_ready| read_data
//
// one item per cycle sustained while out_ready stays high; out_valid rises once the item
// has passed the input register, the register file decode and the result register
// register state changes as the item leaves the input register, so items act in order
// rst is synchronous and clears the register file and both valid flags
// a stalled result holds the pipe; the input register still takes an item while empty

module ring_oscillator_registers (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [7:0]  reg_offset,
  input  logic [31:0] write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data
);
  import rosc_pkg::*;

  // input register stage
  logic         s1_valid;
  rosc_access_t s1_acc;
  logic         s1_fire;
  logic         in_fire;
  logic [31:0]  rdata;

  // stage one moves on when the result register is free or being emptied
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire || (s1_valid && !s1_fire);
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_acc.mode       <= mode;
      s1_acc.reg_offset <= reg_offset;
      s1_acc.write_data <= write_data;
    end
  end

  // decode, read mux and register state
  rosc_regs u_regs (
    .clk   (clk),
    .rst   (rst),
    .fire  (s1_fire),
    .acc   (s1_acc),
    .rdata (rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_fire || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      read_data <= rdata;
    end
  end

`ifndef SYNTH
  a_empty_takes_item: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("empty input register refused an item");

  a_write_reads_zero: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_acc.mode == MODE_WRITE |=> out_valid && read_data == 32'd0)
    else $error("write access returned nonzero data");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !s1_fire)
    else $error("result overwritten while stalled");
`endif

endmodule
